// ===== hw/rtl/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SEQ_W      = 23;
   localparam int HIDX_LSB   = 29;
   localparam int HIDX_W     = 64 - HIDX_LSB;
   localparam int SEQ_LSB    = 3;
   localparam int CNT_OUT_W  = 13;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 112;

   localparam logic [SEQ_W-1:0] SEQ_MAX  = 23'h7FFFFF;
   localparam logic [SEQ_W-1:0] SEQ_ONE  = 23'd1;
   localparam logic [2:0]       MARK_VAL = 3'd2;

   typedef enum logic [2:0] {
      ACT_INIT     = 3'd0,
      ACT_ALLOC    = 3'd1,
      ACT_FREE     = 3'd2,
      ACT_VALIDATE = 3'd3,
      ACT_REQUEST  = 3'd4,
      ACT_WALK_1ST = 3'd5,
      ACT_WALK_NXT = 3'd6,
      ACT_NONE     = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      RC_OK        = 3'd0,
      RC_FULL      = 3'd1,
      RC_BAD_MARK  = 3'd2,
      RC_NOT_REL   = 3'd3,
      RC_IDX_LARGE = 3'd4,
      RC_NONE      = 3'd5
   } result_type;

endpackage

// ===== hw/rtl/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gha_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/generational_handle_allocator_top.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Slot allocator issuing handles of the form index<<29 | seq<<3 | 2.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per action: action, handle and cursor.
//   rsp_* returns exactly one transaction per request, with result code,
//   handle, verdict, cursor and the live and free counts after the action.
//   csr_wr_en/csr_wr_data load the seed used by the init action.
// Steps from acceptance to the response register:
//   init, unused code, early rejects: straight to the response (ST_DONE)
//   free, validate, request in range: one slot read and check (ST_CHK)
//   allocate: fresh slot written, or stack top popped first; with a pending
//     request the stack is searched for it and entries above shifted down
//   request above the used range: each slot up to it pushed (ST_FILL)
//   walks: slots read and examined downward until a live one is found
// Rate is set by the single read port of the slot and stack memories.
// A new request is taken only when the engine is idle; a finished response
// sits in the output register, so the next request is taken while it waits.
// If the receiver stalls with a response still held, the engine holds the
// next result until the register frees. Reset clears counts, pending handle
// and seed (to 1); memory contents are undefined until written.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top #(
   parameter int SLOTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // [2:0] action, [66:3] handle, [79:67] cursor
   input  logic [gha_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] result_code, [66:3] handle_out, [67] is_valid, [80:68] cursor_out,
   // [93:81] live_count, [106:94] free_count, [111:107] zero
   output logic [gha_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [gha_pkg::SEQ_W-1:0]       csr_wr_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int WW = (CW > gha_pkg::CNT_OUT_W) ? CW + 1 : gha_pkg::CNT_OUT_W + 1;
   localparam int SW = gha_pkg::SEQ_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHK, ST_FILL, ST_WK_RD, ST_WK_CHK, ST_UN_RD, ST_UN_CHK,
      ST_SH_RD, ST_SH_WR, ST_UN_COMMIT, ST_POP_RD, ST_POP_CHK, ST_ALLOC_WR,
      ST_DONE
   } state_type;

   state_type                       state_ff;
   logic [CW-1:0]                   live_ff;
   logic [CW-1:0]                   free_ff;
   logic [gha_pkg::SEQ_W-1:0]       seq_ff;
   logic [gha_pkg::SEQ_W-1:0]       seed_ff;
   logic [63:0]                     pend_ff;
   logic [63:0]                     h_ff;
   gha_pkg::action_type             act_ff;
   logic [IW-1:0]                   idx_ff;
   logic [IW-1:0]                   k_ff;
   logic [IW-1:0]                   fill_ff;
   logic [2:0]                      code_ff;
   logic [63:0]                     hout_ff;
   logic                            valid_ff;
   logic [gha_pkg::CNT_OUT_W-1:0]   cur_ff;
   logic [gha_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic                            rsp_valid_ff;

   gha_pkg::action_type             r_act;
   logic [63:0]                     r_h;
   logic [gha_pkg::CNT_OUT_W-1:0]   r_cur;
   logic [gha_pkg::HIDX_W-1:0]      r_hidx;
   logic [CW-1:0]                   used;
   logic [WW-1:0]                   used_w;
   logic [WW-1:0]                   cur_w;

   logic                            slot_we;
   logic [IW-1:0]                   slot_waddr;
   logic [SW-1:0]                   slot_wdata;
   logic [IW-1:0]                   slot_raddr;
   logic [SW-1:0]                   slot_rdata;
   logic                            stk_we;
   logic [IW-1:0]                   stk_waddr;
   logic [IW-1:0]                   stk_wdata;
   logic [IW-1:0]                   stk_raddr;
   logic [IW-1:0]                   stk_rdata;

   logic [gha_pkg::SEQ_W-1:0]       h_seq;
   logic [IW-1:0]                   p_idx;
   logic                            chk_pass;

   assign r_act  = gha_pkg::action_type'(req_tdata[2:0]);
   assign r_h    = req_tdata[66:3];
   assign r_cur  = req_tdata[79:67];
   assign r_hidx = r_h[63:gha_pkg::HIDX_LSB];
   assign used   = live_ff + free_ff;
   assign used_w = WW'(used);
   assign cur_w  = WW'(r_cur);
   assign h_seq  = h_ff[gha_pkg::SEQ_LSB +: gha_pkg::SEQ_W];
   assign p_idx  = pend_ff[gha_pkg::HIDX_LSB +: IW];
   assign chk_pass = (slot_rdata[SW-1:1] == h_seq) && slot_rdata[0];

   function automatic logic [63:0] mk_handle(input logic [IW-1:0] idx,
                                             input logic [gha_pkg::SEQ_W-1:0] seq);
      mk_handle = (64'(idx) << gha_pkg::HIDX_LSB) | (64'(seq) << gha_pkg::SEQ_LSB)
                  | 64'(gha_pkg::MARK_VAL);
   endfunction

   gha_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   gha_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   always_comb begin
      slot_raddr = (state_ff == ST_IDLE) ? r_hidx[IW-1:0] : idx_ff;
      stk_raddr  = k_ff;
      slot_we    = 1'b0;
      slot_waddr = idx_ff;
      slot_wdata = '0;
      stk_we     = 1'b0;
      stk_waddr  = free_ff[IW-1:0];
      stk_wdata  = idx_ff;
      unique case (state_ff)
         ST_CHK: begin
            if (act_ff == gha_pkg::ACT_FREE && chk_pass) begin
               slot_we = 1'b1;
               stk_we  = (free_ff < CW'(SLOTS));
            end
         end
         ST_FILL: begin
            slot_we    = 1'b1;
            slot_waddr = fill_ff;
            stk_we     = 1'b1;
            stk_wdata  = fill_ff;
         end
         ST_SH_WR: begin
            stk_we    = 1'b1;
            stk_waddr = k_ff - IW'(1);
            stk_wdata = stk_rdata;
         end
         ST_UN_COMMIT: begin
            slot_we    = 1'b1;
            slot_waddr = p_idx;
            slot_wdata = {pend_ff[gha_pkg::SEQ_LSB +: gha_pkg::SEQ_W], 1'b1};
         end
         ST_ALLOC_WR: begin
            slot_we    = 1'b1;
            slot_wdata = {seq_ff, 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         free_ff      <= '0;
         seq_ff       <= gha_pkg::SEQ_ONE;
         seed_ff      <= gha_pkg::SEQ_ONE;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  act_ff   <= r_act;
                  h_ff     <= r_h;
                  idx_ff   <= r_hidx[IW-1:0];
                  code_ff  <= gha_pkg::RC_OK;
                  hout_ff  <= '0;
                  valid_ff <= 1'b0;
                  cur_ff   <= '0;
                  state_ff <= ST_DONE;
                  unique case (r_act)
                     gha_pkg::ACT_INIT: begin
                        live_ff <= '0;
                        free_ff <= '0;
                        pend_ff <= '0;
                        seq_ff  <= seed_ff;
                     end
                     gha_pkg::ACT_ALLOC: begin
                        if (live_ff >= CW'(SLOTS)) begin
                           code_ff <= gha_pkg::RC_FULL;
                        end else if (pend_ff != '0
                                     && pend_ff[63:gha_pkg::HIDX_LSB]
                                        < gha_pkg::HIDX_W'(SLOTS)
                                     && free_ff != '0) begin
                           k_ff     <= IW'(free_ff - CW'(1));
                           state_ff <= ST_UN_RD;
                        end else begin
                           pend_ff <= '0;
                           if (free_ff != '0) begin
                              k_ff     <= IW'(free_ff - CW'(1));
                              state_ff <= ST_POP_RD;
                           end else begin
                              idx_ff   <= live_ff[IW-1:0];
                              state_ff <= ST_ALLOC_WR;
                           end
                        end
                     end
                     gha_pkg::ACT_FREE, gha_pkg::ACT_VALIDATE: begin
                        if (r_h == '0) begin
                           valid_ff <= 1'b1;
                        end else if (r_h[2:0] != gha_pkg::MARK_VAL) begin
                           if (r_act == gha_pkg::ACT_FREE) begin
                              code_ff <= gha_pkg::RC_BAD_MARK;
                           end
                        end else if (r_hidx >= gha_pkg::HIDX_W'(used)) begin
                           if (r_act == gha_pkg::ACT_FREE) begin
                              code_ff <= gha_pkg::RC_IDX_LARGE;
                           end
                        end else begin
                           state_ff <= ST_CHK;
                        end
                        if (r_act == gha_pkg::ACT_FREE) begin
                           valid_ff <= 1'b0;
                        end
                     end
                     gha_pkg::ACT_REQUEST: begin
                        if (r_h[2:0] != gha_pkg::MARK_VAL) begin
                           code_ff <= gha_pkg::RC_BAD_MARK;
                        end else if (r_hidx < gha_pkg::HIDX_W'(used)) begin
                           state_ff <= ST_CHK;
                        end else if (r_hidx >= gha_pkg::HIDX_W'(SLOTS)) begin
                           code_ff <= gha_pkg::RC_IDX_LARGE;
                        end else begin
                           fill_ff  <= used[IW-1:0];
                           state_ff <= ST_FILL;
                        end
                     end
                     gha_pkg::ACT_WALK_1ST, gha_pkg::ACT_WALK_NXT: begin
                        if ((r_act == gha_pkg::ACT_WALK_1ST && live_ff == '0)
                            || (r_act == gha_pkg::ACT_WALK_NXT
                                && (r_cur == '0 || used == '0))) begin
                           code_ff <= gha_pkg::RC_NONE;
                           cur_ff  <= '1;
                        end else begin
                           if (r_act == gha_pkg::ACT_WALK_1ST || cur_w > used_w) begin
                              idx_ff <= IW'(used - CW'(1));
                           end else begin
                              idx_ff <= IW'(r_cur - gha_pkg::CNT_OUT_W'(1));
                           end
                           state_ff <= ST_WK_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_CHK: begin
               state_ff <= ST_DONE;
               unique case (act_ff)
                  gha_pkg::ACT_FREE: begin
                     if (chk_pass) begin
                        if (free_ff < CW'(SLOTS)) begin
                           free_ff <= free_ff + CW'(1);
                        end
                        live_ff <= live_ff - CW'(1);
                     end else begin
                        code_ff <= gha_pkg::RC_NONE;
                     end
                  end
                  gha_pkg::ACT_VALIDATE: begin
                     valid_ff <= chk_pass;
                  end
                  default: begin
                     if (slot_rdata[0]) begin
                        code_ff <= gha_pkg::RC_NOT_REL;
                     end else begin
                        pend_ff <= h_ff;
                     end
                  end
               endcase
            end
            ST_FILL: begin
               free_ff <= free_ff + CW'(1);
               if (fill_ff == idx_ff) begin
                  pend_ff  <= h_ff;
                  state_ff <= ST_DONE;
               end else begin
                  fill_ff <= fill_ff + IW'(1);
               end
            end
            ST_WK_RD: begin
               state_ff <= ST_WK_CHK;
            end
            ST_WK_CHK: begin
               if (slot_rdata[0]) begin
                  hout_ff  <= mk_handle(idx_ff, slot_rdata[SW-1:1]);
                  cur_ff   <= gha_pkg::CNT_OUT_W'(idx_ff);
                  state_ff <= ST_DONE;
               end else if (idx_ff == '0) begin
                  code_ff  <= gha_pkg::RC_NONE;
                  cur_ff   <= '1;
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_ff - IW'(1);
                  state_ff <= ST_WK_RD;
               end
            end
            ST_UN_RD: begin
               state_ff <= ST_UN_CHK;
            end
            ST_UN_CHK: begin
               if (stk_rdata == p_idx) begin
                  if (CW'(k_ff) + CW'(1) < free_ff) begin
                     k_ff     <= k_ff + IW'(1);
                     state_ff <= ST_SH_RD;
                  end else begin
                     state_ff <= ST_UN_COMMIT;
                  end
               end else if (k_ff == '0) begin
                  pend_ff  <= '0;
                  k_ff     <= IW'(free_ff - CW'(1));
                  state_ff <= ST_POP_RD;
               end else begin
                  k_ff     <= k_ff - IW'(1);
                  state_ff <= ST_UN_RD;
               end
            end
            ST_SH_RD: begin
               state_ff <= ST_SH_WR;
            end
            ST_SH_WR: begin
               if (CW'(k_ff) + CW'(1) < free_ff) begin
                  k_ff     <= k_ff + IW'(1);
                  state_ff <= ST_SH_RD;
               end else begin
                  state_ff <= ST_UN_COMMIT;
               end
            end
            ST_UN_COMMIT: begin
               free_ff  <= free_ff - CW'(1);
               live_ff  <= live_ff + CW'(1);
               hout_ff  <= pend_ff;
               pend_ff  <= '0;
               state_ff <= ST_DONE;
            end
            ST_POP_RD: begin
               state_ff <= ST_POP_CHK;
            end
            ST_POP_CHK: begin
               idx_ff   <= stk_rdata;
               free_ff  <= free_ff - CW'(1);
               state_ff <= ST_ALLOC_WR;
            end
            ST_ALLOC_WR: begin
               live_ff  <= live_ff + CW'(1);
               hout_ff  <= mk_handle(idx_ff, seq_ff);
               seq_ff   <= (seq_ff == gha_pkg::SEQ_MAX) ? gha_pkg::SEQ_ONE
                                                        : seq_ff + gha_pkg::SEQ_ONE;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'b0,
                                   gha_pkg::CNT_OUT_W'(free_ff),
                                   gha_pkg::CNT_OUT_W'(live_ff),
                                   cur_ff, valid_ff, hout_ff, code_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
